### rtl/yuvrgb_pkg.sv
// Package for the two-pixel YUV 4:2:0 to RGB565 converter.
// Holds the BT.601 Q20 coefficients, term types and the clip and pack functions.
// No dependencies.
`default_nettype none

package yuvrgb_pkg;

    localparam int unsigned SampleW = 8;
    localparam int unsigned PixelW  = 16;
    localparam int unsigned DataW   = 32;
    localparam int unsigned AddrW   = 3;
    localparam int unsigned CoefW   = 23;
    localparam int unsigned DiffW   = SampleW + 1;
    localparam int unsigned ProdW   = CoefW + DiffW;
    localparam int unsigned TermW   = 10;
    localparam int unsigned SumW    = 11;
    localparam int unsigned FracW   = 20;

    localparam logic signed [CoefW-1:0] CoefY  = 23'sd1220542;
    localparam logic signed [CoefW-1:0] CoefRv = 23'sd1673527;
    localparam logic signed [CoefW-1:0] CoefGv = 23'sd852492;
    localparam logic signed [CoefW-1:0] CoefGu = 23'sd409993;
    localparam logic signed [CoefW-1:0] CoefBu = 23'sd2116026;

    localparam logic signed [DiffW-1:0] LumaOffset   = 9'sd16;
    localparam logic signed [DiffW-1:0] ChromaOffset = 9'sd128;

    // Register index of the byte-swap control, taken from paddr[2].
    localparam logic RegSwap = 1'b0;

    typedef logic signed [DiffW-1:0] t_diff;
    typedef logic signed [ProdW-1:0] t_prod;
    typedef logic signed [TermW-1:0] t_term;
    typedef logic signed [SumW-1:0]  t_sum;

    typedef struct packed {
        t_term rv;
        t_term gv;
        t_term gu;
        t_term bu;
    } t_chroma;

    // floor(coef * x / 2^20); the arithmetic shift gives floor for negative products.
    function automatic t_term q20_term(input logic signed [CoefW-1:0] coef, input t_diff x);
        t_prod p;
        begin
            p = coef * x;
            return p[FracW+TermW-1:FracW];
        end
    endfunction

    function automatic logic [SampleW-1:0] clip8(input t_sum v);
        begin
            if (v[SumW-1] || (v == '0)) begin
                return '0;
            end else if (v[SumW-2:SampleW] != '0) begin
                return '1;
            end else begin
                return v[SampleW-1:0];
            end
        end
    endfunction

    function automatic logic [PixelW-1:0] pack565(input logic [SampleW-1:0] r,
                                                  input logic [SampleW-1:0] g,
                                                  input logic [SampleW-1:0] b,
                                                  input logic swap);
        begin
            if (swap) begin
                return {g[4:2], b[7:3], r[7:3], g[7:5]};
            end else begin
                return {r[7:3], g[7:2], b[7:3]};
            end
        end
    endfunction

endpackage

`default_nettype wire

### rtl/yuvrgb_if.sv
// Valid/ready channel interfaces of the converter: YUV pair in, RGB565 pair out.
// Depends on yuvrgb_pkg for field widths.
`default_nettype none

interface yuvrgb_in_if;
    logic                              valid;
    logic                              ready;
    logic [yuvrgb_pkg::SampleW-1:0]    luma_first;
    logic [yuvrgb_pkg::SampleW-1:0]    luma_second;
    logic [yuvrgb_pkg::SampleW-1:0]    chroma_blue;
    logic [yuvrgb_pkg::SampleW-1:0]    chroma_red;

    modport source(output valid, output luma_first, output luma_second,
                   output chroma_blue, output chroma_red, input ready);
    modport sink(input valid, input luma_first, input luma_second,
                 input chroma_blue, input chroma_red, output ready);
endinterface

interface yuvrgb_out_if;
    logic                              valid;
    logic                              ready;
    logic [yuvrgb_pkg::PixelW-1:0]     pixel_first;
    logic [yuvrgb_pkg::PixelW-1:0]     pixel_second;

    modport source(output valid, output pixel_first, output pixel_second, input ready);
    modport sink(input valid, input pixel_first, input pixel_second, output ready);
endinterface

`default_nettype wire

### rtl/yuvrgb_pixel.sv
// Final stage for one pixel: adds luma and chroma terms, clips and packs RGB565.
// Depends on yuvrgb_pkg.
`default_nettype none

module yuvrgb_pixel (
    input  wire yuvrgb_pkg::t_term               i_yt,
    input  wire yuvrgb_pkg::t_chroma             i_chroma,
    input  wire logic                            i_swap,
    output logic [yuvrgb_pkg::PixelW-1:0]        o_pixel
);
    import yuvrgb_pkg::*;

    t_sum                 n_r_sum;
    t_sum                 n_g_sum;
    t_sum                 n_b_sum;
    logic [SampleW-1:0]   n_r;
    logic [SampleW-1:0]   n_g;
    logic [SampleW-1:0]   n_b;

    always_comb begin
        n_r_sum = SumW'(i_yt) + SumW'(i_chroma.rv);
        n_g_sum = SumW'(i_yt) - (SumW'(i_chroma.gv) + SumW'(i_chroma.gu));
        n_b_sum = SumW'(i_yt) + SumW'(i_chroma.bu);
        n_r     = clip8(n_r_sum);
        n_g     = clip8(n_g_sum);
        n_b     = clip8(n_b_sum);
        o_pixel = pack565(n_r, n_g, n_b, i_swap);
    end

endmodule

`default_nettype wire

### rtl/yuv420_to_rgb565_pair.sv
// Two-pixel BT.601 YUV 4:2:0 to RGB565 converter with an APB control register.
// Items pass the input, term and pixel register stages in turn to the output.
// Throughput: one pixel pair per cycle unless the output stalls; three register
// stages collapse bubbles, taking items while a result waits until all hold data.
// Reset clears all stage valid bits and the byte-swap register.
// Depends on yuvrgb_pkg, yuvrgb_if and yuvrgb_pixel.
`default_nettype none

module yuv420_to_rgb565_pair (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    yuvrgb_in_if.sink                              i_in,
    yuvrgb_out_if.source                           o_out,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [yuvrgb_pkg::AddrW-1:0]      paddr,
    input  wire logic [yuvrgb_pkg::DataW-1:0]      pwdata,
    output logic [yuvrgb_pkg::DataW-1:0]           prdata,
    output logic                                   pready
);
    import yuvrgb_pkg::*;

    logic                 r_swap;

    logic                 r_s1_valid;
    logic [SampleW-1:0]   r_y0;
    logic [SampleW-1:0]   r_y1;
    logic [SampleW-1:0]   r_u;
    logic [SampleW-1:0]   r_v;

    logic                 r_s2_valid;
    t_term                r_yt0;
    t_term                r_yt1;
    t_chroma              r_chroma;

    logic                 r_s3_valid;
    logic [PixelW-1:0]    r_pix0;
    logic [PixelW-1:0]    r_pix1;

    logic                 n_s1_ready;
    logic                 n_s2_ready;
    logic                 n_s3_ready;
    t_diff                n_dy0;
    t_diff                n_dy1;
    t_diff                n_du;
    t_diff                n_dv;
    t_chroma              n_chroma;
    logic [PixelW-1:0]    n_pix0;
    logic [PixelW-1:0]    n_pix1;
    logic                 n_cfg_wr;

    assign pready   = 1'b1;
    assign n_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegSwap);
    assign prdata   = (paddr[2] == RegSwap) ? {{(DataW-1){1'b0}}, r_swap} : '0;

    assign n_s3_ready = !r_s3_valid || o_out.ready;
    assign n_s2_ready = !r_s2_valid || n_s3_ready;
    assign n_s1_ready = !r_s1_valid || n_s2_ready;
    assign i_in.ready = n_s1_ready;

    assign o_out.valid        = r_s3_valid;
    assign o_out.pixel_first  = r_pix0;
    assign o_out.pixel_second = r_pix1;

    always_comb begin
        n_dy0       = $signed({1'b0, r_y0}) - LumaOffset;
        n_dy1       = $signed({1'b0, r_y1}) - LumaOffset;
        n_du        = $signed({1'b0, r_u}) - ChromaOffset;
        n_dv        = $signed({1'b0, r_v}) - ChromaOffset;
        n_chroma.rv = q20_term(CoefRv, n_dv);
        n_chroma.gv = q20_term(CoefGv, n_dv);
        n_chroma.gu = q20_term(CoefGu, n_du);
        n_chroma.bu = q20_term(CoefBu, n_du);
    end

    yuvrgb_pixel u_pix0 (
        .i_yt     (r_yt0),
        .i_chroma (r_chroma),
        .i_swap   (r_swap),
        .o_pixel  (n_pix0)
    );

    yuvrgb_pixel u_pix1 (
        .i_yt     (r_yt1),
        .i_chroma (r_chroma),
        .i_swap   (r_swap),
        .o_pixel  (n_pix1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap     <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (n_cfg_wr) begin
                r_swap <= pwdata[0];
            end
            if (n_s1_ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (n_s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (n_s3_ready) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_s1_ready && i_in.valid) begin
            r_y0 <= i_in.luma_first;
            r_y1 <= i_in.luma_second;
            r_u  <= i_in.chroma_blue;
            r_v  <= i_in.chroma_red;
        end
        if (n_s2_ready && r_s1_valid) begin
            r_yt0    <= q20_term(CoefY, n_dy0);
            r_yt1    <= q20_term(CoefY, n_dy1);
            r_chroma <= n_chroma;
        end
        if (n_s3_ready && r_s2_valid) begin
            r_pix0 <= n_pix0;
            r_pix1 <= n_pix1;
        end
    end

endmodule

`default_nettype wire

### rtl/yuvrgb_chk.sv
// Port-level checker for the converter, attached to the top level by bind.
// Depends on yuvrgb_pkg.
`default_nettype none

module yuvrgb_chk (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_ready,
    input  wire logic                              i_out_valid,
    input  wire logic                              i_out_ready,
    input  wire logic [yuvrgb_pkg::PixelW-1:0]     i_pixel_first,
    input  wire logic [yuvrgb_pkg::PixelW-1:0]     i_pixel_second,
    input  wire logic                              i_psel,
    input  wire logic                              i_penable,
    input  wire logic                              i_pwrite,
    input  wire logic [yuvrgb_pkg::AddrW-1:0]      i_paddr,
    input  wire logic [yuvrgb_pkg::DataW-1:0]      i_pwdata,
    input  wire logic [yuvrgb_pkg::DataW-1:0]      i_prdata,
    input  wire logic                              i_pready
);
    import yuvrgb_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_pixel_first) && $stable(i_pixel_second))
        else $error("output pixels changed while stalled");

    a_full_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled while the output is not blocked");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("pipeline not empty after reset");

    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && i_penable && i_pwrite && i_pready && (i_paddr[2] == RegSwap)
        ##1 (i_paddr[2] == RegSwap) |-> i_prdata[0] == $past(i_pwdata[0]))
        else $error("byte-swap register does not read back the written value");

endmodule

bind yuv420_to_rgb565_pair yuvrgb_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_pixel_first  (o_out.pixel_first),
    .i_pixel_second (o_out.pixel_second),
    .i_psel         (psel),
    .i_penable      (penable),
    .i_pwrite       (pwrite),
    .i_paddr        (paddr),
    .i_pwdata       (pwdata),
    .i_prdata       (prdata),
    .i_pready       (pready)
);

`default_nettype wire
